/* rtl/core/dss_pkg.sv */
// ----------------------------------------------------------------------------
// dss_pkg
// Shared widths, reset values and register indexes for the SCAN scheduler.
// ----------------------------------------------------------------------------
package dss_pkg;

	localparam int MAX_REQUESTS_DEF = 32;

	localparam int CYL_W  = 16;
	localparam int MOVE_W = 17;

	localparam logic [CYL_W-1:0] UPPER_LIMIT_RST    = 16'd199;
	localparam logic [CYL_W-1:0] START_POSITION_RST = 16'd0;

	typedef enum logic {
		REG_UPPER_LIMIT    = 1'b0,
		REG_START_POSITION = 1'b1
	} reg_idx_t;

endpackage

/* rtl/core/dss_ram.sv */
// ----------------------------------------------------------------------------
// dss_ram
// Request store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dss_ram #(
	parameter int DEPTH = 34,
	parameter int AW    = 6
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [dss_pkg::CYL_W-1:0] wdata,
	input  logic [AW-1:0]            raddr,
	output logic [dss_pkg::CYL_W-1:0] rdata
);
	import dss_pkg::*;

	logic [CYL_W-1:0] mem [DEPTH];
	logic [CYL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/dss_seq.sv */
// ----------------------------------------------------------------------------
// dss_seq
// Sequencer: loads requests, insertion-sorts the store in place, locates the
// head entry and walks the sweep into the output register.
// ----------------------------------------------------------------------------
module dss_seq #(
	parameter int MAX_REQUESTS = dss_pkg::MAX_REQUESTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [dss_pkg::CYL_W-1:0]  upper_limit,
	input  logic [dss_pkg::CYL_W-1:0]  start_position,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [dss_pkg::CYL_W-1:0]  cylinder,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [dss_pkg::CYL_W-1:0]  position,
	output logic [dss_pkg::MOVE_W-1:0] total_movement,
	output logic                       final_res
);
	import dss_pkg::*;

	localparam int DEPTH = MAX_REQUESTS + 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	typedef enum logic [9:0] {
		ST_LOAD       = 10'b00_0000_0001,
		ST_APP_UL     = 10'b00_0000_0010,
		ST_APP_HD     = 10'b00_0000_0100,
		ST_SORT_KEY   = 10'b00_0000_1000,
		ST_SORT_LATCH = 10'b00_0001_0000,
		ST_SORT_CMP   = 10'b00_0010_0000,
		ST_FIND_RD    = 10'b00_0100_0000,
		ST_FIND_CMP   = 10'b00_1000_0000,
		ST_EMIT_RD    = 10'b01_0000_0000,
		ST_EMIT_LOAD  = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	logic [CW-1:0]     count_q;
	logic [AW-1:0]     a_q;
	logic [AW-1:0]     b_q;
	logic [AW-1:0]     i_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     p_q;
	logic              up_q;
	logic [CYL_W-1:0]  key_q;
	logic [CYL_W-1:0]  cur_q;
	logic [MOVE_W-1:0] sum_q;

	logic              out_valid_q;
	logic [CYL_W-1:0]  position_q;
	logic [MOVE_W-1:0] movement_q;
	logic              final_q;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CYL_W-1:0]  mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [CYL_W-1:0]  mem_rdata;

	logic              in_fire;
	logic              out_free;
	logic              shift;
	logic              sort_done;
	logic              p_has_next;
	logic              emit_last;
	logic [CYL_W-1:0]  seek_dist;
	logic [MOVE_W-1:0] sum_next;

	dss_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign in_ready   = (state_q == ST_LOAD);
	assign in_fire    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign shift      = (b_q != '0) && (mem_rdata > key_q);
	assign sort_done  = (CW'(a_q) + CW'(1)) == count_q;
	assign p_has_next = (CW'(p_q) + CW'(1)) < count_q;
	assign emit_last  = up_q ? (!p_has_next && (idx_q == '0)) : (p_q == '0);
	assign seek_dist  = (mem_rdata >= cur_q) ? (mem_rdata - cur_q) : (cur_q - mem_rdata);
	assign sum_next   = sum_q + MOVE_W'(seek_dist);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = cylinder;
		mem_raddr = p_q;
		unique case (state_q)
			ST_LOAD: begin
				mem_we = in_fire && (count_q < CW'(MAX_REQUESTS));
			end
			ST_APP_UL: begin
				mem_we    = 1'b1;
				mem_wdata = upper_limit;
			end
			ST_APP_HD: begin
				mem_we    = 1'b1;
				mem_wdata = start_position;
			end
			ST_SORT_KEY: begin
				mem_raddr = a_q;
			end
			ST_SORT_LATCH: begin
				mem_raddr = a_q - AW'(1);
			end
			ST_SORT_CMP: begin
				mem_we    = 1'b1;
				mem_waddr = b_q;
				mem_wdata = shift ? mem_rdata : key_q;
				mem_raddr = b_q - AW'(2);
			end
			ST_FIND_RD: begin
				mem_raddr = i_q;
			end
			ST_FIND_CMP: begin
				mem_raddr = i_q;
			end
			ST_EMIT_RD: begin
				mem_raddr = p_q;
			end
			ST_EMIT_LOAD: begin
				mem_raddr = p_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (count_q < CW'(MAX_REQUESTS)) begin
							count_q <= count_q + CW'(1);
						end
						if (last) begin
							state_q <= ST_APP_UL;
						end
					end
				end
				ST_APP_UL: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_APP_HD;
				end
				ST_APP_HD: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_SORT_KEY;
				end
				ST_SORT_KEY: begin
					state_q <= ST_SORT_LATCH;
				end
				ST_SORT_LATCH: begin
					state_q <= ST_SORT_CMP;
				end
				ST_SORT_CMP: begin
					if (!shift) begin
						state_q <= sort_done ? ST_FIND_RD : ST_SORT_KEY;
					end
				end
				ST_FIND_RD: begin
					state_q <= ST_FIND_CMP;
				end
				ST_FIND_CMP: begin
					if (mem_rdata == start_position) begin
						state_q <= ST_EMIT_RD;
					end else begin
						state_q <= ST_FIND_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LOAD;
				end
				ST_EMIT_LOAD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (emit_last) begin
							count_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_APP_HD: begin
				a_q <= AW'(1);
			end
			ST_SORT_LATCH: begin
				key_q <= mem_rdata;
				b_q   <= a_q;
			end
			ST_SORT_CMP: begin
				if (shift) begin
					b_q <= b_q - AW'(1);
				end else begin
					a_q <= a_q + AW'(1);
					i_q <= '0;
				end
			end
			ST_FIND_CMP: begin
				if (mem_rdata == start_position) begin
					idx_q <= i_q;
					cur_q <= start_position;
					sum_q <= '0;
					if ((CW'(i_q) + CW'(1)) < count_q) begin
						p_q  <= i_q + AW'(1);
						up_q <= 1'b1;
					end else begin
						p_q  <= i_q - AW'(1);
						up_q <= 1'b0;
					end
				end else begin
					i_q <= i_q + AW'(1);
				end
			end
			ST_EMIT_LOAD: begin
				if (out_free) begin
					position_q <= mem_rdata;
					movement_q <= sum_next;
					final_q    <= emit_last;
					cur_q      <= mem_rdata;
					sum_q      <= sum_next;
					if (up_q && p_has_next) begin
						p_q <= p_q + AW'(1);
					end else if (up_q) begin
						p_q  <= idx_q - AW'(1);
						up_q <= 1'b0;
					end else begin
						p_q <= p_q - AW'(1);
					end
				end
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign position       = position_q;
	assign total_movement = movement_q;
	assign final_res      = final_q;

endmodule

/* rtl/core/disk_scan_scheduler.sv */
// ----------------------------------------------------------------------------
// disk_scan_scheduler
// SCAN (elevator) disk scheduler over a batch of cylinder requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, cylinder, last): one request per
//   transaction, one per cycle while loading. A transaction with last set
//   closes the batch; requests beyond MAX_REQUESTS are dropped.
//   Output channel (out_valid/out_ready, position, total_movement,
//   final_res): entry count + 1 transactions per batch, final_res on the last.
//   After the closing request upper_limit and start_position are appended,
//   the n = count + 2 entries are insertion-sorted in place (SORT_KEY and
//   SORT_LATCH per key, SORT_CMP per compare and shift, bounded by the
//   single read port of the store), FIND_RD and FIND_CMP scan entries for
//   the head, then EMIT_RD and EMIT_LOAD emit each result. in_ready stays
//   low until the last result has entered the output register.
//   A stalled receiver holds the output register and the walk waits.
//   Reset: upper_limit 199, start_position 0, batch empty, no output
//   pending. The store needs no clearing pass.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
// ----------------------------------------------------------------------------
module disk_scan_scheduler #(
	parameter int MAX_REQUESTS = dss_pkg::MAX_REQUESTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [dss_pkg::CYL_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [dss_pkg::CYL_W-1:0]  cylinder,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [dss_pkg::CYL_W-1:0]  position,
	output logic [dss_pkg::MOVE_W-1:0] total_movement,
	output logic                       final_res
);
	import dss_pkg::*;

	logic [CYL_W-1:0] upper_limit_q;
	logic [CYL_W-1:0] start_position_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_limit_q    <= UPPER_LIMIT_RST;
			start_position_q <= START_POSITION_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_UPPER_LIMIT:    upper_limit_q    <= cfg_data;
				REG_START_POSITION: start_position_q <= cfg_data;
				default:            upper_limit_q    <= upper_limit_q;
			endcase
		end
	end

	dss_seq #(
		.MAX_REQUESTS(MAX_REQUESTS)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.upper_limit   (upper_limit_q),
		.start_position(start_position_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cylinder      (cylinder),
		.last          (last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.position      (position),
		.total_movement(total_movement),
		.final_res     (final_res)
	);

endmodule

/* verif/dss_scoreboard_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dss_scoreboard_pkg
// Seek-order predictor and result checker for the SCAN disk scheduler.
// Requests are collected per batch; a closing request yields the expected
// seek sequence, which is compared field by field with the output stream.
// ----------------------------------------------------------------------------
package dss_scoreboard_pkg;

	import dss_pkg::*;

	typedef struct packed {
		logic [CYL_W-1:0]  position;
		logic [MOVE_W-1:0] total_movement;
		logic              final_res;
	} seek_step_t;

	class seek_scoreboard;

		logic [CYL_W-1:0] upper_limit;
		logic [CYL_W-1:0] start_position;
		logic [CYL_W-1:0] batch[$];
		seek_step_t       expected_steps[$];
		int unsigned      max_requests;
		int               errors;

		function new(input int unsigned max_req);
			max_requests   = max_req;
			upper_limit    = UPPER_LIMIT_RST;
			start_position = START_POSITION_RST;
			errors         = 0;
		endfunction

		function void set_register(input reg_idx_t idx, input logic [CYL_W-1:0] val);
			case (idx)
				REG_UPPER_LIMIT: begin
					upper_limit = val;
				end
				REG_START_POSITION: begin
					start_position = val;
				end
				default: begin
				end
			endcase
		endfunction

		function int pending();
			return expected_steps.size();
		endfunction

		// accepted request transaction; a closing one produces the seek sequence
		function void note_request(input logic [CYL_W-1:0] cyl, input logic lst);
			logic [CYL_W-1:0]  keys[$];
			logic [CYL_W-1:0]  route[$];
			logic [CYL_W-1:0]  k;
			logic [CYL_W-1:0]  head;
			logic [MOVE_W-1:0] travelled;
			seek_step_t        step;
			int                i;
			int                j;
			int                pivot;

			if (batch.size() < max_requests)
				batch.push_back(cyl);
			if (!lst)
				return;

			keys = batch;
			keys.push_back(upper_limit);
			keys.push_back(start_position);
			for (i = 1; i < keys.size(); i++) begin
				k = keys[i];
				j = i;
				while (j > 0 && keys[j-1] > k) begin
					keys[j] = keys[j-1];
					j--;
				end
				keys[j] = k;
			end

			pivot = 0;
			while (pivot < keys.size() && keys[pivot] != start_position)
				pivot++;
			for (i = pivot + 1; i < keys.size(); i++)
				route.push_back(keys[i]);
			for (i = pivot - 1; i >= 0; i--)
				route.push_back(keys[i]);

			head      = start_position;
			travelled = '0;
			for (i = 0; i < route.size(); i++) begin
				if (route[i] >= head)
					travelled = travelled + (route[i] - head);
				else
					travelled = travelled + (head - route[i]);
				head                = route[i];
				step.position       = route[i];
				step.total_movement = travelled;
				step.final_res      = (i == route.size() - 1);
				expected_steps.push_back(step);
			end
			batch.delete();
		endfunction

		function void check_result(input logic [CYL_W-1:0] pos, input logic [MOVE_W-1:0] mov,
				input logic fin);
			seek_step_t want;

			if (expected_steps.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result transaction, position %0d movement %0d",
						$time, pos, mov);
				return;
			end
			want = expected_steps.pop_front();
			if (want.position !== pos || want.total_movement !== mov
					|| want.final_res !== fin) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result mismatch: position %0d/%0d movement %0d/%0d final %0b/%0b (exp/act)",
						$time, want.position, pos, want.total_movement, mov,
						want.final_res, fin);
			end
		endfunction

		function int finish_check();
			if (expected_steps.size() != 0) begin
				errors++;
				$display("%0d result transactions never arrived", expected_steps.size());
			end
			return errors;
		endfunction

	endclass

endpackage

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the SCAN disk scheduler: directed batches over the register
// extremes, then random batches with random idling on both channels and one
// long output stall, all results checked against the seek-order predictor.
// ----------------------------------------------------------------------------
module tb_top;

	import dss_pkg::*;
	import dss_scoreboard_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int MAX_REQ       = MAX_REQUESTS_DEF;
	localparam int RANDOM_ITEMS  = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 6000;
	localparam int HOLD_CYCLES   = 400;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [CYL_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [CYL_W-1:0]  cylinder;
	logic              last;
	logic              out_valid;
	logic              out_ready;
	logic [CYL_W-1:0]  position;
	logic [MOVE_W-1:0] total_movement;
	logic              final_res;

	seek_scoreboard sb;
	int             requests_sent = 0;
	int             results_seen  = 0;
	int             idle_cycles   = 0;

	disk_scan_scheduler #(
		.MAX_REQUESTS(MAX_REQ)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cylinder       (cylinder),
		.last           (last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.position       (position),
		.total_movement (total_movement),
		.final_res      (final_res)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic send_request(input logic [CYL_W-1:0] cyl, input logic lst);
		if (requests_sent < 120 || requests_sent >= 220) begin
			while ($urandom_range(99) < 6) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		cylinder <= cyl;
		last     <= lst;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CYL_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.set_register(idx, val);
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_request(cylinder, last);
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(position, total_movement, final_res);
			results_seen++;
		end
	end

	// watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : receiver
		int  hold;
		bit  held;

		hold = 0;
		held = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (!held && results_seen >= 60) begin
				held = 1;
				hold = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (results_seen >= 300 && results_seen < 500)
					|| ($urandom_range(99) >= 6);
			end
		end
	end

	initial begin : stimulus
		logic [CYL_W-1:0] cyl;
		logic [CYL_W-1:0] prev_cyl;
		logic [CYL_W-1:0] val;
		int               len;
		int               b;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_UPPER_LIMIT;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		cylinder  <= '0;
		last      <= 1'b0;
		sb = new(MAX_REQ);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: request above the limit, request on the head, small batch
		send_request(16'hFFFF, 1'b1);
		send_request(16'h0000, 1'b1);
		send_request(16'd50, 1'b0);
		send_request(16'd150, 1'b0);
		send_request(16'd10, 1'b1);
		drain();

		write_reg(REG_UPPER_LIMIT, 16'hFFFF);
		write_reg(REG_START_POSITION, 16'h8000);
		send_request(16'hFFFF, 1'b0);
		send_request(16'h0000, 1'b0);
		send_request(16'h8000, 1'b0);
		send_request(16'h7FFF, 1'b0);
		send_request(16'h8000, 1'b1);
		drain();

		// head above the limit
		write_reg(REG_UPPER_LIMIT, 16'h0000);
		write_reg(REG_START_POSITION, 16'hFFFF);
		send_request(16'h5555, 1'b0);
		send_request(16'hAAAA, 1'b0);
		send_request(16'hFFFF, 1'b1);
		send_request(16'h0000, 1'b1);
		drain();

		prev_cyl      = '0;
		requests_sent = 0;
		while (requests_sent < RANDOM_ITEMS) begin
			if ($urandom_range(9) == 0) begin
				drain();
				case ($urandom_range(3))
					0: val = '0;
					1: val = 16'hFFFF;
					2: val = CYL_W'($urandom_range(400));
					default: val = CYL_W'($urandom());
				endcase
				write_reg(reg_idx_t'($urandom_range(1)), val);
			end
			if ($urandom_range(7) == 0)
				len = $urandom_range(MAX_REQ + 4, 20);
			else
				len = $urandom_range(8, 1);
			for (b = 0; b < len; b++) begin
				case ($urandom_range(7))
					0: cyl = CYL_W'($urandom_range(255));
					1: cyl = sb.start_position;
					2: cyl = prev_cyl;
					3: cyl = CYL_W'(sb.upper_limit + $urandom_range(2) - 1);
					default: cyl = CYL_W'($urandom());
				endcase
				prev_cyl = cyl;
				send_request(cyl, b == len - 1);
			end
		end
		drain();

		if (sb.finish_check() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/dss_pkg.sv
rtl/core/dss_ram.sv
rtl/core/dss_seq.sv
rtl/core/disk_scan_scheduler.sv
verif/dss_scoreboard_pkg.sv
verif/tb_top.sv
